// ----- sv/obbaabb_pkg.sv -----
// shared types, constants and the sine/cosine table for the obb versus aabb overlap test
package obbaabb_pkg;

	localparam int COORD_WIDTH      = 20;
	localparam int ANGLE_BITS       = 16;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int HALF_BITS        = 18;
	localparam int MARGIN_BITS      = 16;

	// trig entries are q1.14, range -16384 to 16384
	localparam int TRIG_W     = 16;
	localparam int ONE_SHIFT  = 14;
	localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
	localparam int IDX_PROD_W = ANGLE_BITS + IDX_W;

	// doubled lengths: rectangle extents with margin, box extents with margin
	localparam int RW_W   = ((COORD_WIDTH + 1 > MARGIN_BITS + 2) ?
		COORD_WIDTH + 1 : MARGIN_BITS + 2) + 1;
	localparam int HW_W   = HALF_BITS + 3;
	localparam int A_W    = (RW_W > HW_W) ? RW_W : HW_W;
	localparam int PROD_W = A_W + TRIG_W;
	localparam int CMP_W  = PROD_W + 3;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MARGIN = REG_IDX_W'(0);

	// separating axis codes
	localparam logic [2:0] AXIS_LOCAL_X = 3'd0;
	localparam logic [2:0] AXIS_LOCAL_Z = 3'd1;
	localparam logic [2:0] AXIS_WORLD_X = 3'd2;
	localparam logic [2:0] AXIS_WORLD_Z = 3'd3;
	localparam logic [2:0] AXIS_NONE    = 3'd4;

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] box_center_x;
		logic signed [COORD_WIDTH-1:0] box_center_z;
		logic        [ANGLE_BITS-1:0]  heading;
		logic        [HALF_BITS-1:0]   box_half_width;
		logic        [HALF_BITS-1:0]   box_half_depth;
		logic signed [COORD_WIDTH-1:0] rect_min_x;
		logic signed [COORD_WIDTH-1:0] rect_min_z;
		logic signed [COORD_WIDTH-1:0] rect_max_x;
		logic signed [COORD_WIDTH-1:0] rect_max_z;
	} query_t;

	typedef struct packed {
		logic       overlap;
		logic [2:0] separating_axis;
	} result_t;

	typedef logic signed [TRIG_W-1:0] trig_rom_t [SINE_TABLE_DEPTH];

	function automatic longint q30_to_q14(input longint v);
		longint t;
		t = v;
		if (t < 0) t = 0;
		if (t > longint'(ONE_Q30)) t = longint'(ONE_Q30);
		return (t + 32768) >>> 16;
	endfunction

	// shift and subtract quotient for the series denominators
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rmd;
		quo = '0;
		rmd = '0;
		for (int b = 63; b >= 0; b--) begin
			rmd = {rmd[62:0], num[b]};
			if (rmd >= den) begin
				rmd = rmd - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// taylor series per entry on the first-quadrant angle, signs from the quadrant
	function automatic trig_rom_t build_trig_rom(input logic want_cos);
		trig_rom_t rom;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned a;
		longint unsigned ts;
		longint unsigned tc;
		longint unsigned k;
		longint ss;
		longint cs;
		longint sv;
		longint cv;
		longint s_out;
		longint c_out;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			quad = (64'(4) * 64'(i)) / SINE_TABLE_DEPTH;
			rem  = 64'(4) * 64'(i) - quad * SINE_TABLE_DEPTH;
			a    = (HALF_PI_Q30 * rem) / SINE_TABLE_DEPTH;
			ts = a;
			tc = ONE_Q30;
			ss = longint'(a);
			cs = longint'(ONE_Q30);
			for (k = 1; k <= 10; k++) begin
				ts = udiv((((ts * a) >> 30) * a) >> 30, (2 * k) * (2 * k + 1));
				tc = udiv((((tc * a) >> 30) * a) >> 30, (2 * k - 1) * (2 * k));
				if (k[0]) begin
					ss = ss - longint'(ts);
					cs = cs - longint'(tc);
				end else begin
					ss = ss + longint'(ts);
					cs = cs + longint'(tc);
				end
			end
			sv = q30_to_q14(ss);
			cv = q30_to_q14(cs);
			case (quad[1:0])
				2'd0: begin
					s_out = sv;
					c_out = cv;
				end
				2'd1: begin
					s_out = cv;
					c_out = -sv;
				end
				2'd2: begin
					s_out = -sv;
					c_out = -cv;
				end
				default: begin
					s_out = -cv;
					c_out = sv;
				end
			endcase
			rom[i] = want_cos ? TRIG_W'(c_out) : TRIG_W'(s_out);
		end
		return rom;
	endfunction

	localparam trig_rom_t SIN_ROM = build_trig_rom(1'b0);
	localparam trig_rom_t COS_ROM = build_trig_rom(1'b1);

endpackage

// ----- sv/obb_aabb_overlap_test.sv -----
// oriented box versus axis-aligned rectangle separating axis test, five-stage pipeline
//
//   channel  | direction | handshake                    | payload
//   query    | in        | query_valid / query_ready    | obbaabb_pkg::query_t
//   result   | out       | result_valid / result_ready  | obbaabb_pkg::result_t
//   config   | in        | apb psel/penable/pwrite      | margin at byte address 0
//
// one transaction per cycle while the result side keeps taking results, through the stages:
// table read, sums of doubled lengths, products, projection sums, compare.
// every stage holds on its own when it is full and the one after it cannot move, so the query
// side keeps taking transactions while a result waits until all five stages fill.
// reset clears the stage valid bits and sets margin to zero; the trig table is a constant rom.
module obb_aabb_overlap_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                query_valid,
	output logic                                query_ready,
	input  obbaabb_pkg::query_t                 query,
	output logic                                result_valid,
	input  logic                                result_ready,
	output obbaabb_pkg::result_t                result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [obbaabb_pkg::PADDR_W-1:0]     paddr,
	input  logic [obbaabb_pkg::PDATA_W-1:0]     pwdata,
	output logic [obbaabb_pkg::PDATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int CW  = obbaabb_pkg::COORD_WIDTH;
	localparam int AW  = obbaabb_pkg::A_W;
	localparam int TW  = obbaabb_pkg::TRIG_W;
	localparam int PW  = obbaabb_pkg::PROD_W;
	localparam int XW  = obbaabb_pkg::CMP_W;
	localparam int SH  = obbaabb_pkg::ONE_SHIFT;

	function automatic logic signed [AW-1:0] sx(input logic signed [CW-1:0] v);
		return AW'(v);
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [AW-1:0] a,
			input logic signed [TW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic signed [XW-1:0] ep(input logic signed [PW-1:0] v);
		return XW'(v);
	endfunction

	function automatic logic signed [XW-1:0] ea(input logic signed [AW-1:0] v);
		return XW'(v);
	endfunction

	function automatic logic signed [XW-1:0] absx(input logic signed [XW-1:0] v);
		return v[XW-1] ? -v : v;
	endfunction

	// configuration register
	logic [obbaabb_pkg::MARGIN_BITS-1:0] margin_q;
	logic [obbaabb_pkg::REG_IDX_W-1:0]   reg_idx;
	logic                                cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[obbaabb_pkg::PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_write && reg_idx == obbaabb_pkg::REG_MARGIN) begin
			margin_q <= pwdata[obbaabb_pkg::MARGIN_BITS-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			obbaabb_pkg::REG_MARGIN: prdata = obbaabb_pkg::PDATA_W'(margin_q);
			default:                 prdata = '0;
		endcase
	end

	// stage valids and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5 = !v_s5 || result_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign query_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= query_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: capture query, registered table read
	logic [obbaabb_pkg::IDX_PROD_W-1:0] idx_prod;
	logic [obbaabb_pkg::IDX_W-1:0]      trig_idx;
	obbaabb_pkg::query_t                q_s1;
	logic signed [TW-1:0]               sin_s1, cos_s1;

	assign idx_prod = obbaabb_pkg::IDX_PROD_W'(query.heading) *
		obbaabb_pkg::IDX_PROD_W'(obbaabb_pkg::SINE_TABLE_DEPTH);
	assign trig_idx = idx_prod[obbaabb_pkg::IDX_PROD_W-1:obbaabb_pkg::ANGLE_BITS];

	always_ff @(posedge clk) begin
		if (rdy_s1 && query_valid) begin
			q_s1   <= query;
			sin_s1 <= obbaabb_pkg::SIN_ROM[trig_idx];
			cos_s1 <= obbaabb_pkg::COS_ROM[trig_idx];
		end
	end

	// stage 2: doubled center offset and extents, trig magnitudes
	logic signed [AW-1:0] m2;
	logic signed [AW-1:0] hw2_s2, hd2_s2, rw2_s2, rh2_s2, dx2_s2, dz2_s2;
	logic signed [TW-1:0] sin_s2, cos_s2, asin_s2, acos_s2;

	assign m2 = AW'(margin_q) <<< 1;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			hw2_s2  <= (AW'(q_s1.box_half_width) + AW'(margin_q)) <<< 1;
			hd2_s2  <= (AW'(q_s1.box_half_depth) + AW'(margin_q)) <<< 1;
			// inverted rectangles give a negative extent, kept as is
			rw2_s2  <= sx(q_s1.rect_max_x) - sx(q_s1.rect_min_x) + m2;
			rh2_s2  <= sx(q_s1.rect_max_z) - sx(q_s1.rect_min_z) + m2;
			dx2_s2  <= sx(q_s1.rect_min_x) + sx(q_s1.rect_max_x) - (sx(q_s1.box_center_x) <<< 1);
			dz2_s2  <= sx(q_s1.rect_min_z) + sx(q_s1.rect_max_z) - (sx(q_s1.box_center_z) <<< 1);
			sin_s2  <= sin_s1;
			cos_s2  <= cos_s1;
			asin_s2 <= sin_s1[TW-1] ? -sin_s1 : sin_s1;
			acos_s2 <= cos_s1[TW-1] ? -cos_s1 : cos_s1;
		end
	end

	// stage 3: products
	logic signed [PW-1:0] dx2c_s3, dz2s_s3, dx2s_s3, dz2c_s3;
	logic signed [PW-1:0] rw2ac_s3, rh2as_s3, rw2as_s3, rh2ac_s3;
	logic signed [PW-1:0] hw2ac_s3, hd2as_s3, hw2as_s3, hd2ac_s3;
	logic signed [AW-1:0] hw2_s3, hd2_s3, rw2_s3, rh2_s3, dx2_s3, dz2_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			dx2c_s3  <= mul(dx2_s2, cos_s2);
			dz2s_s3  <= mul(dz2_s2, sin_s2);
			dx2s_s3  <= mul(dx2_s2, sin_s2);
			dz2c_s3  <= mul(dz2_s2, cos_s2);
			rw2ac_s3 <= mul(rw2_s2, acos_s2);
			rh2as_s3 <= mul(rh2_s2, asin_s2);
			rw2as_s3 <= mul(rw2_s2, asin_s2);
			rh2ac_s3 <= mul(rh2_s2, acos_s2);
			hw2ac_s3 <= mul(hw2_s2, acos_s2);
			hd2as_s3 <= mul(hd2_s2, asin_s2);
			hw2as_s3 <= mul(hw2_s2, asin_s2);
			hd2ac_s3 <= mul(hd2_s2, acos_s2);
			hw2_s3   <= hw2_s2;
			hd2_s3   <= hd2_s2;
			rw2_s3   <= rw2_s2;
			rh2_s3   <= rh2_s2;
			dx2_s3   <= dx2_s2;
			dz2_s3   <= dz2_s2;
		end
	end

	// stage 4: projections onto each axis, all at scale 2^14
	logic signed [XW-1:0] dxl_s4, dzl_s4, lhs2_s4, lhs3_s4;
	logic signed [XW-1:0] rhs0_s4, rhs1_s4, rhs2_s4, rhs3_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			dxl_s4  <= ep(dx2c_s3) + ep(dz2s_s3);
			dzl_s4  <= ep(dz2c_s3) - ep(dx2s_s3);
			lhs2_s4 <= absx(ea(dx2_s3)) <<< SH;
			lhs3_s4 <= absx(ea(dz2_s3)) <<< SH;
			rhs0_s4 <= (ea(hw2_s3) <<< SH) + ep(rw2ac_s3) + ep(rh2as_s3);
			rhs1_s4 <= (ea(hd2_s3) <<< SH) + ep(rw2as_s3) + ep(rh2ac_s3);
			rhs2_s4 <= ep(hw2ac_s3) + ep(hd2as_s3) + (ea(rw2_s3) <<< SH);
			rhs3_s4 <= ep(hw2as_s3) + ep(hd2ac_s3) + (ea(rh2_s3) <<< SH);
		end
	end

	// stage 5: strict compares, first separating axis wins; touching overlaps
	logic [2:0] axis_sel;

	always_comb begin
		if (absx(dxl_s4) > rhs0_s4) begin
			axis_sel = obbaabb_pkg::AXIS_LOCAL_X;
		end else if (absx(dzl_s4) > rhs1_s4) begin
			axis_sel = obbaabb_pkg::AXIS_LOCAL_Z;
		end else if (lhs2_s4 > rhs2_s4) begin
			axis_sel = obbaabb_pkg::AXIS_WORLD_X;
		end else if (lhs3_s4 > rhs3_s4) begin
			axis_sel = obbaabb_pkg::AXIS_WORLD_Z;
		end else begin
			axis_sel = obbaabb_pkg::AXIS_NONE;
		end
	end

	obbaabb_pkg::result_t res_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			res_s5.overlap         <= (axis_sel == obbaabb_pkg::AXIS_NONE);
			res_s5.separating_axis <= axis_sel;
		end
	end

	assign result_valid = v_s5;
	assign result       = res_s5;

endmodule

// ----- bench/overlap_checker.sv -----
`timescale 1ns / 1ps
// checker for the obb versus aabb overlap test: tracks margin, predicts each result, compares
module overlap_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            query_valid,
	input  logic                            query_ready,
	input  obbaabb_pkg::query_t             query,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  obbaabb_pkg::result_t            result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [obbaabb_pkg::PADDR_W-1:0] paddr,
	input  logic [obbaabb_pkg::PDATA_W-1:0] pwdata,
	input  logic [obbaabb_pkg::PDATA_W-1:0] prdata,
	input  logic                            pready,
	output int                              outstanding,
	output int                              fail_count
);
	import obbaabb_pkg::*;

	localparam longint TRIG_ONE = 64'sd16384;
	localparam int MAX_PRINTED = 100;

	longint sin_q14 [SINE_TABLE_DEPTH];
	longint cos_q14 [SINE_TABLE_DEPTH];
	logic [MARGIN_BITS-1:0] margin = '0;
	result_t verdicts [$];
	result_t want;
	int pending_q = 0;
	int errors = 0;

	assign outstanding = pending_q;
	assign fail_count = errors;

	function automatic longint q30_round_q14(input longint v);
		if (v < 0) v = 0;
		if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
		return (v + 32768) >>> 16;
	endfunction

	// full-turn table, first-quadrant taylor series mirrored by quadrant
	initial begin : fill_trig
		longint unsigned quad, rem, ang, tsin, tcos;
		longint ssum, csum, sq, cq;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			quad = (64'd4 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
			rem  = 64'd4 * 64'(i) - quad * 64'(SINE_TABLE_DEPTH);
			ang  = (HALF_PI_Q30 * rem) / 64'(SINE_TABLE_DEPTH);
			tsin = ang;
			tcos = ONE_Q30;
			ssum = longint'(ang);
			csum = longint'(ONE_Q30);
			for (int k = 1; k <= 10; k++) begin
				tsin = ((((tsin * ang) >> 30) * ang) >> 30) / 64'((2 * k) * (2 * k + 1));
				tcos = ((((tcos * ang) >> 30) * ang) >> 30) / 64'((2 * k - 1) * (2 * k));
				if (k % 2 == 1) begin
					ssum = ssum - longint'(tsin);
					csum = csum - longint'(tcos);
				end else begin
					ssum = ssum + longint'(tsin);
					csum = csum + longint'(tcos);
				end
			end
			sq = q30_round_q14(ssum);
			cq = q30_round_q14(csum);
			case (quad[1:0])
				2'd0: begin
					sin_q14[i] = sq;
					cos_q14[i] = cq;
				end
				2'd1: begin
					sin_q14[i] = cq;
					cos_q14[i] = -sq;
				end
				2'd2: begin
					sin_q14[i] = -sq;
					cos_q14[i] = -cq;
				end
				default: begin
					sin_q14[i] = -cq;
					cos_q14[i] = sq;
				end
			endcase
		end
	end

	function automatic longint magn(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// lengths doubled so rectangle centers stay exact, projections scaled by 2^14
	function automatic result_t predict_overlap(input query_t q);
		longint cx, cz, minx, minz, maxx, maxz, m, hw2, hd2, rw2, rh2, dx2, dz2;
		longint s, c, abs_s, abs_c, dxl, dzl;
		longint idx;
		logic [2:0] axis;
		result_t r;
		m    = longint'(margin);
		cx   = longint'(q.box_center_x);
		cz   = longint'(q.box_center_z);
		minx = longint'(q.rect_min_x);
		minz = longint'(q.rect_min_z);
		maxx = longint'(q.rect_max_x);
		maxz = longint'(q.rect_max_z);
		hw2  = 2 * (longint'(q.box_half_width) + m);
		hd2  = 2 * (longint'(q.box_half_depth) + m);
		idx  = (longint'(q.heading) * SINE_TABLE_DEPTH) >>> ANGLE_BITS;
		if (idx >= SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH - 1;
		s = sin_q14[idx];
		c = cos_q14[idx];
		abs_s = magn(s);
		abs_c = magn(c);
		// inverted rectangles keep their negative extent
		rw2 = (maxx - minx) + 2 * m;
		rh2 = (maxz - minz) + 2 * m;
		dx2 = (minx + maxx) - 2 * cx;
		dz2 = (minz + maxz) - 2 * cz;
		dxl = dx2 * c + dz2 * s;
		dzl = -dx2 * s + dz2 * c;
		if (magn(dxl) > hw2 * TRIG_ONE + rw2 * abs_c + rh2 * abs_s)
			axis = AXIS_LOCAL_X;
		else if (magn(dzl) > hd2 * TRIG_ONE + rw2 * abs_s + rh2 * abs_c)
			axis = AXIS_LOCAL_Z;
		else if (magn(dx2) * TRIG_ONE > hw2 * abs_c + hd2 * abs_s + rw2 * TRIG_ONE)
			axis = AXIS_WORLD_X;
		else if (magn(dz2) * TRIG_ONE > hw2 * abs_s + hd2 * abs_c + rh2 * TRIG_ONE)
			axis = AXIS_WORLD_Z;
		else
			axis = AXIS_NONE;
		r.overlap = (axis == AXIS_NONE);
		r.separating_axis = axis;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin = '0;
			verdicts.delete();
		end else begin
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_MARGIN) begin
				if (pwrite)
					margin = pwdata[MARGIN_BITS-1:0];
				else if (prdata !== PDATA_W'(margin))
					report_mismatch($sformatf("margin read %h, expected %h", prdata, margin));
			end
			if (query_valid && query_ready)
				verdicts.push_back(predict_overlap(query));
			if (result_valid && result_ready) begin
				if (verdicts.size() == 0) begin
					report_mismatch($sformatf("result %p with no query waiting", result));
				end else begin
					want = verdicts.pop_front();
					if (result.overlap !== want.overlap)
						report_mismatch($sformatf("overlap %b, expected %b",
							result.overlap, want.overlap));
					if (result.separating_axis !== want.separating_axis)
						report_mismatch($sformatf("separating_axis %0d, expected %0d",
							result.separating_axis, want.separating_axis));
				end
			end
		end
		pending_q <= verdicts.size();
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// top of the overlap test bench: clock, reset, query and margin stimulus, final verdict
module tb;
	import obbaabb_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 250;
	localparam int TIMEOUT_NS = 400000;
	localparam logic [PADDR_W-1:0] MARGIN_ADDR = {REG_MARGIN, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic query_valid = 1'b0;
	logic query_ready;
	query_t query = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	int outstanding;
	int fail_count;

	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int stall_left = 0;
	int hold;

	always #1 clk = ~clk;

	obb_aabb_overlap_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	overlap_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.query        (query),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	// result side: a random stall of result_ready after each transaction, with calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else if (result_valid && result_ready) begin
			if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
			hold = rx_calm ? 0 : $urandom_range(0, 3);
			result_ready <= (hold == 0);
			stall_left <= (hold == 0) ? 0 : hold - 1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_query(input query_t q);
		int gap;
		query <= q;
		query_valid <= 1'b1;
		@(posedge clk);
		while (!query_ready) @(posedge clk);
		gap = tx_calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			query_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_queries();
		query_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_margin(input logic [PDATA_W-1:0] value);
		apb_access(1'b1, MARGIN_ADDR, value);
		apb_access(1'b0, MARGIN_ADDR, '0);
	endtask

	function automatic query_t make_query(input int cx, input int cz, input int hdg,
			input int hw, input int hd, input int minx, input int minz,
			input int maxx, input int maxz);
		query_t q;
		q.box_center_x   = COORD_WIDTH'(cx);
		q.box_center_z   = COORD_WIDTH'(cz);
		q.heading        = ANGLE_BITS'(hdg);
		q.box_half_width = HALF_BITS'(hw);
		q.box_half_depth = HALF_BITS'(hd);
		q.rect_min_x     = COORD_WIDTH'(minx);
		q.rect_min_z     = COORD_WIDTH'(minz);
		q.rect_max_x     = COORD_WIDTH'(maxx);
		q.rect_max_z     = COORD_WIDTH'(maxz);
		return q;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] fit_coord(input longint v);
		longint hi;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return COORD_WIDTH'(v);
	endfunction

	// mostly a rectangle placed near the box at one scale, so every axis gets exercised
	function automatic query_t rand_query();
		logic [191:0] noise;
		query_t q;
		int unsigned span;
		longint rcx, rcz, rhx, rhz;
		logic signed [COORD_WIDTH-1:0] swap;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		q = noise[$bits(query_t)-1:0];
		if ($urandom_range(0, 99) < 20) return q;
		span = 1 << $urandom_range(4, 17);
		q.box_half_width = HALF_BITS'($urandom_range(0, span));
		q.box_half_depth = HALF_BITS'($urandom_range(0, span));
		if ($urandom_range(0, 9) == 0) q.box_half_width = '0;
		if ($urandom_range(0, 3) == 0)
			q.heading = ANGLE_BITS'($urandom_range(0, 3) * 16384 + $urandom_range(0, 127));
		rcx = longint'(q.box_center_x) + longint'($urandom_range(0, 4 * span)) - 2 * span;
		rcz = longint'(q.box_center_z) + longint'($urandom_range(0, 4 * span)) - 2 * span;
		rhx = longint'($urandom_range(0, span));
		rhz = longint'($urandom_range(0, span));
		q.rect_min_x = fit_coord(rcx - rhx);
		q.rect_max_x = fit_coord(rcx + rhx);
		q.rect_min_z = fit_coord(rcz - rhz);
		q.rect_max_z = fit_coord(rcz + rhz);
		if ($urandom_range(0, 19) == 0) begin
			swap = q.rect_min_x;
			q.rect_min_x = q.rect_max_x;
			q.rect_max_x = swap;
		end
		if ($urandom_range(0, 19) == 0) begin
			swap = q.rect_min_z;
			q.rect_min_z = q.rect_max_z;
			q.rect_max_z = swap;
		end
		return q;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 49) == 0) tx_calm = ~tx_calm;
			send_query(rand_query());
		end
	endtask

	task automatic run_directed();
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// one clean separation per axis
		send_query(make_query(0, 0, 0, 256, 256, 1024, -256, 2048, 256));
		send_query(make_query(0, 0, 0, 256, 256, -256, 1024, 256, 2048));
		send_query(make_query(0, 0, 8192, 256, 256, 400, -1000, 1000, 1000));
		send_query(make_query(0, 0, 8192, 256, 256, -1000, 400, 1000, 1000));
		// touching is overlap, one step further is not
		send_query(make_query(0, 0, 0, 256, 256, 256, 0, 512, 0));
		send_query(make_query(0, 0, 0, 256, 256, 257, 0, 512, 0));
		// inverted rectangle
		send_query(make_query(0, 0, 0, 256, 256, 100, -50, -100, 50));
		send_query(make_query(0, 0, 0, 0, 0, 100, 0, -100, 0));
		send_query(make_query(0, 0, 0, 0, 0, 0, 100, 0, -100));
		// field extremes
		send_query(make_query(524287, 524287, 65535, 262143, 262143,
			-524288, -524288, 524287, 524287));
		send_query(make_query(-524288, -524288, 0, 262143, 262143,
			-524288, -524288, 524287, 524287));
		send_query(make_query(524287, 524287, 0, 0, 0,
			-524288, -524288, -524288, -524288));
		send_query(make_query(-524288, 524287, 32768, 262143, 0,
			524287, -524288, 524287, -524288));
		send_query(make_query(0, 0, 0, 0, 0, 524287, 524287, -524288, -524288));
		// heading corners and table index truncation
		send_query(make_query(0, 0, 16384, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 32768, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 49152, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 65535, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 63, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 64, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(0, 0, 1, 1000, 10, 900, -5, 1100, 5));
		send_query(make_query(300, -300, 21845, 5, 5, 300, -300, 300, -300));
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain_queries();
		// the spare slot holds no register, margin must stay at zero
		apb_access(1'b1, SPARE_ADDR, '1);
		apb_access(1'b0, MARGIN_ADDR, '0);
		set_margin(PDATA_W'(65535));
		run_random(PHASE_ITEMS);
		drain_queries();
		set_margin('0);
		run_random(PHASE_ITEMS / 2);
		drain_queries();
		run_random(PHASE_ITEMS / 2);
		drain_queries();
		// upper data bits are outside the register
		set_margin({16'($urandom), 16'($urandom_range(1, 65534))});
		run_random(PHASE_ITEMS);
		drain_queries();
		set_margin(PDATA_W'(1));
		run_random(PHASE_ITEMS);
		drain_queries();
		set_margin(PDATA_W'($urandom_range(0, 1023)));
		run_random(PHASE_ITEMS);
		drain_queries();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("** obb_aabb_overlap_test: PASSED **");
		end else begin
			$display("** obb_aabb_overlap_test: FAILED **");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** obb_aabb_overlap_test: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/obbaabb_pkg.sv
sv/obb_aabb_overlap_test.sv
bench/overlap_checker.sv
bench/tb.sv
